// ----- design/ikd_pkg.sv -----
`default_nettype none
package ikd_pkg;
	localparam int NUM_BANDS = 4;
	localparam int EDGE_W = 16;
	localparam int PEAK_W = 17;
	localparam int KNOT_W = 4;
	localparam int IDX_W = 3;
	localparam logic [PEAK_W-1:0] PEAK_MAX = 17'h1FFFF;
	localparam logic [7:0] HYS_MAX = 8'd253;

	localparam logic [IDX_W-1:0] REG_GYRO_BIAS = 3'd0;
	localparam logic [IDX_W-1:0] REG_ACCEL_BIAS = 3'd1;
	localparam logic [IDX_W-1:0] REG_GRAVITY = 3'd2;
	localparam logic [IDX_W-1:0] REG_HYSTERESIS = 3'd3;
	localparam logic [IDX_W-1:0] REG_RATE_THR = 3'd4;
	localparam logic [IDX_W-1:0] REG_ACCEL_THR = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_KNOTS = 3'd6;

	typedef struct packed {
		logic [47:0] gyro_bias;
		logic [47:0] accel_bias;
		logic [15:0] gravity_magnitude;
		logic [7:0] hysteresis_q8;
		logic [63:0] rate_thresholds;
		logic [63:0] accel_thresholds;
		logic [3:0] max_knots;
	} ikd_cfg_t;
endpackage
`default_nettype wire

// ----- design/imu_excitation_knot_density_core.sv -----
// the front end squares and sums the bias-corrected components one at a time, and the sums
// pass through a two-entry queue to the back end, which takes their square roots for the peaks
// a new sample is taken only after the front end has pushed the previous sums into the queue;
// back end's bit-serial square root sets the pace; a segment end adds band counting and emit
// reset: arst_n clears peaks and queues, empties the result register, sets previous knot
// count to 1 and loads the register defaults
`default_nettype none
module imu_excitation_knot_density_core #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [SAMPLE_BITS-1:0] gyro_x,
	input wire logic [SAMPLE_BITS-1:0] gyro_y,
	input wire logic [SAMPLE_BITS-1:0] gyro_z,
	input wire logic [SAMPLE_BITS-1:0] acc_x,
	input wire logic [SAMPLE_BITS-1:0] acc_y,
	input wire logic [SAMPLE_BITS-1:0] acc_z,
	input wire logic segment_end,
	output logic empty,
	input wire logic pop,
	output logic [3:0] knot_count,
	output logic [16:0] peak_rate,
	output logic [16:0] peak_accel_dev,
	input wire logic wr_en,
	input wire logic [ikd_pkg::IDX_W-1:0] wr_index,
	input wire logic [63:0] wr_data
);
	import ikd_pkg::*;

	localparam int DW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
	localparam int SUMW = 2 * DW + 2;

	ikd_cfg_t cfg_q;
	logic f_push;
	logic f_full;
	logic [SUMW-1:0] f_gsum;
	logic [SUMW-1:0] f_asum;
	logic f_seg;
	logic b_pop;
	logic b_empty;
	logic [2*SUMW:0] b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gyro_bias <= '0;
			cfg_q.accel_bias <= '0;
			cfg_q.gravity_magnitude <= '0;
			cfg_q.hysteresis_q8 <= '0;
			cfg_q.rate_thresholds <= '1;
			cfg_q.accel_thresholds <= '1;
			cfg_q.max_knots <= 4'd5;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GYRO_BIAS: cfg_q.gyro_bias <= wr_data[47:0];
				REG_ACCEL_BIAS: cfg_q.accel_bias <= wr_data[47:0];
				REG_GRAVITY: cfg_q.gravity_magnitude <= wr_data[15:0];
				REG_HYSTERESIS: cfg_q.hysteresis_q8 <= wr_data[7:0];
				REG_RATE_THR: cfg_q.rate_thresholds <= wr_data;
				REG_ACCEL_THR: cfg_q.accel_thresholds <= wr_data;
				REG_MAX_KNOTS: cfg_q.max_knots <= wr_data[3:0];
				default: begin
				end
			endcase
		end
	end

	ikd_front #(.SAMPLE_BITS(SAMPLE_BITS), .DW(DW), .SUMW(SUMW)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.gyro_x(gyro_x),
		.gyro_y(gyro_y),
		.gyro_z(gyro_z),
		.acc_x(acc_x),
		.acc_y(acc_y),
		.acc_z(acc_z),
		.segment_end(segment_end),
		.gyro_bias(cfg_q.gyro_bias),
		.accel_bias(cfg_q.accel_bias),
		.q_push(f_push),
		.q_full(f_full),
		.q_gsum(f_gsum),
		.q_asum(f_asum),
		.q_seg(f_seg)
	);

	ikd_fifo #(.W(2 * SUMW + 1)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(f_push),
		.wdata({f_seg, f_asum, f_gsum}),
		.full(f_full),
		.rd(b_pop),
		.rdata(b_data),
		.empty(b_empty)
	);

	ikd_back #(.DW(DW), .SUMW(SUMW)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(b_empty),
		.q_pop(b_pop),
		.q_gsum(b_data[SUMW-1:0]),
		.q_asum(b_data[2*SUMW-1:SUMW]),
		.q_seg(b_data[2*SUMW]),
		.cfg(cfg_q),
		.empty(empty),
		.pop(pop),
		.knot_count(knot_count),
		.peak_rate(peak_rate),
		.peak_accel_dev(peak_accel_dev)
	);
endmodule
`default_nettype wire

// ----- design/ikd_fifo.sv -----
`default_nettype none
module ikd_fifo #(
	parameter int W = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire logic [W-1:0] wdata,
	output logic full,
	input wire logic rd,
	output logic [W-1:0] rdata,
	output logic empty
);
	logic [W-1:0] mem_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= ~wp_q;
			if (rd && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr && !full) - 2'(rd && !empty);
		end
	end
endmodule
`default_nettype wire

// ----- design/ikd_front.sv -----
`default_nettype none
module ikd_front #(
	parameter int SAMPLE_BITS = 16,
	parameter int DW = 17,
	parameter int SUMW = 36
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [SAMPLE_BITS-1:0] gyro_x,
	input wire logic [SAMPLE_BITS-1:0] gyro_y,
	input wire logic [SAMPLE_BITS-1:0] gyro_z,
	input wire logic [SAMPLE_BITS-1:0] acc_x,
	input wire logic [SAMPLE_BITS-1:0] acc_y,
	input wire logic [SAMPLE_BITS-1:0] acc_z,
	input wire logic segment_end,
	input wire logic [47:0] gyro_bias,
	input wire logic [47:0] accel_bias,
	output logic q_push,
	input wire logic q_full,
	output logic [SUMW-1:0] q_gsum,
	output logic [SUMW-1:0] q_asum,
	output logic q_seg
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQ = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0] state_q;
	logic [2:0] cnt_q;
	logic [DW-1:0] d_q [6];
	logic [SUMW-1:0] gsum_q;
	logic [SUMW-1:0] asum_q;
	logic seg_q;
	logic [DW-1:0] mag;
	logic [2*DW-1:0] sq;

	function automatic logic [DW-1:0] diff(input logic [SAMPLE_BITS-1:0] s,
			input logic [15:0] b);
		logic [DW-1:0] se;
		logic [DW-1:0] be;
		begin
			se = {{(DW-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
			be = {{(DW-16){b[15]}}, b};
			return se - be;
		end
	endfunction

	assign full = (state_q != ST_IDLE);
	assign mag = d_q[0][DW-1] ? (~d_q[0] + 1'b1) : d_q[0];
	assign sq = mag * mag;
	assign q_push = (state_q == ST_PUSH) && !q_full;
	assign q_gsum = gsum_q;
	assign q_asum = asum_q;
	assign q_seg = seg_q;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			d_q[0] <= diff(gyro_x, gyro_bias[15:0]);
			d_q[1] <= diff(gyro_y, gyro_bias[31:16]);
			d_q[2] <= diff(gyro_z, gyro_bias[47:32]);
			d_q[3] <= diff(acc_x, accel_bias[15:0]);
			d_q[4] <= diff(acc_y, accel_bias[31:16]);
			d_q[5] <= diff(acc_z, accel_bias[47:32]);
			seg_q <= segment_end;
			gsum_q <= '0;
			asum_q <= '0;
		end else if (state_q == ST_SQ) begin
			for (int k = 0; k < 5; k++) d_q[k] <= d_q[k+1];
			if (cnt_q < 3'd3) gsum_q <= gsum_q + SUMW'(sq);
			else asum_q <= asum_q + SUMW'(sq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						state_q <= ST_SQ;
						cnt_q <= 3'd0;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!q_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/ikd_back.sv -----
`default_nettype none
module ikd_back #(
	parameter int DW = 17,
	parameter int SUMW = 36
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	output logic q_pop,
	input wire logic [SUMW-1:0] q_gsum,
	input wire logic [SUMW-1:0] q_asum,
	input wire logic q_seg,
	input wire ikd_pkg::ikd_cfg_t cfg,
	output logic empty,
	input wire logic pop,
	output logic [3:0] knot_count,
	output logic [16:0] peak_rate,
	output logic [16:0] peak_accel_dev
);
	import ikd_pkg::*;

	localparam int N = SUMW / 2;
	localparam int RTW = DW + 1;
	localparam int RW = DW + 4;
	localparam int CW = $clog2(N + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROOT = 3'd1;
	localparam logic [2:0] ST_PEAK = 3'd2;
	localparam logic [2:0] ST_BAND = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [CW-1:0] it_q;
	logic [SUMW-1:0] gx_q;
	logic [SUMW-1:0] ax_q;
	logic [RW-1:0] grem_q;
	logic [RW-1:0] arem_q;
	logic [RTW-1:0] groot_q;
	logic [RTW-1:0] aroot_q;
	logic seg_q;
	logic [PEAK_W-1:0] rpeak_q;
	logic [PEAK_W-1:0] apeak_q;
	logic [KNOT_W-1:0] prev_q;
	logic [1:0] b_q;
	logic [2:0] rcnt_q;
	logic [2:0] acnt_q;
	logic rstop_q;
	logic astop_q;
	logic ovalid_q;
	logic [3:0] okn_q;
	logic [PEAK_W-1:0] orate_q;
	logic [PEAK_W-1:0] oacc_q;

	logic [RW+RTW-1:0] gstep;
	logic [RW+RTW-1:0] astep;
	logic [PEAK_W-1:0] wn;
	logic [PEAK_W-1:0] an;
	logic [PEAK_W-1:0] gext;
	logic [PEAK_W-1:0] dev;
	logic [7:0] hc;
	logic [8:0] scale;
	logic [KNOT_W-1:0] held;
	logic [EDGE_W-1:0] redge;
	logic [EDGE_W-1:0] aedge;
	logic [24:0] rscaled;
	logic [24:0] ascaled;
	logic below;
	logic rok;
	logic aok;
	logic [2:0] bands;
	logic [3:0] cap;
	logic [3:0] kn;
	logic [3:0] knots;
	logic out_free;

	function automatic logic [RW+RTW-1:0] sq_step(input logic [RW-1:0] rem,
			input logic [RTW-1:0] root, input logic [1:0] pair);
		logic [RW-1:0] r2;
		logic [RW-1:0] trial;
		begin
			r2 = {rem[RW-3:0], pair};
			trial = RW'({root, 2'b01});
			if (r2 >= trial) return {r2 - trial, root[RTW-2:0], 1'b1};
			return {r2, root[RTW-2:0], 1'b0};
		end
	endfunction

	assign gstep = sq_step(grem_q, groot_q, gx_q[SUMW-1:SUMW-2]);
	assign astep = sq_step(arem_q, aroot_q, ax_q[SUMW-1:SUMW-2]);

	assign wn = (|groot_q[RTW-1:PEAK_W]) ? PEAK_MAX : groot_q[PEAK_W-1:0];
	assign an = (|aroot_q[RTW-1:PEAK_W]) ? PEAK_MAX : aroot_q[PEAK_W-1:0];
	assign gext = PEAK_W'(cfg.gravity_magnitude);
	assign dev = (an >= gext) ? (an - gext) : (gext - an);

	assign hc = (cfg.hysteresis_q8 > HYS_MAX) ? HYS_MAX : cfg.hysteresis_q8;
	assign scale = 9'd256 - {1'b0, hc};
	assign held = (prev_q != '0) ? (prev_q - 1'b1) : '0;
	assign redge = cfg.rate_thresholds[16*b_q +: 16];
	assign aedge = cfg.accel_thresholds[16*b_q +: 16];
	assign rscaled = redge * scale;
	assign ascaled = aedge * scale;
	assign below = ({2'b00, b_q} < held);
	assign rok = below ? ({rpeak_q, 8'h00} >= rscaled) : (rpeak_q >= PEAK_W'(redge));
	assign aok = below ? ({apeak_q, 8'h00} >= ascaled) : (apeak_q >= PEAK_W'(aedge));

	assign bands = (rcnt_q > acnt_q) ? rcnt_q : acnt_q;
	assign cap = (cfg.max_knots == 4'd0) ? 4'd1 : cfg.max_knots;
	assign kn = {1'b0, bands} + 4'd1;
	assign knots = (kn > cap) ? cap : kn;

	assign out_free = !ovalid_q || pop;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign empty = !ovalid_q;
	assign knot_count = okn_q;
	assign peak_rate = orate_q;
	assign peak_accel_dev = oacc_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				gx_q <= q_gsum;
				ax_q <= q_asum;
				seg_q <= q_seg;
				grem_q <= '0;
				arem_q <= '0;
				groot_q <= '0;
				aroot_q <= '0;
			end
			ST_ROOT: begin
				gx_q <= gx_q << 2;
				ax_q <= ax_q << 2;
				{grem_q, groot_q} <= gstep;
				{arem_q, aroot_q} <= astep;
			end
			default: begin
			end
		endcase
		if (state_q == ST_EMIT && out_free) begin
			okn_q <= knots;
			orate_q <= rpeak_q;
			oacc_q <= apeak_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			it_q <= '0;
			rpeak_q <= '0;
			apeak_q <= '0;
			prev_q <= 4'd1;
			b_q <= '0;
			rcnt_q <= '0;
			acnt_q <= '0;
			rstop_q <= 1'b0;
			astop_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) ovalid_q <= 1'b1;
			else if (pop && ovalid_q) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_ROOT;
						it_q <= '0;
					end
				end
				ST_ROOT: begin
					it_q <= it_q + 1'b1;
					if (it_q == CW'(N - 1)) state_q <= ST_PEAK;
				end
				ST_PEAK: begin
					if (wn > rpeak_q) rpeak_q <= wn;
					if (dev > apeak_q) apeak_q <= dev;
					b_q <= '0;
					rcnt_q <= '0;
					acnt_q <= '0;
					rstop_q <= 1'b0;
					astop_q <= 1'b0;
					state_q <= seg_q ? ST_BAND : ST_IDLE;
				end
				ST_BAND: begin
					if (!rstop_q && rok) rcnt_q <= rcnt_q + 3'd1;
					else rstop_q <= 1'b1;
					if (!astop_q && aok) acnt_q <= acnt_q + 3'd1;
					else astop_q <= 1'b1;
					b_q <= b_q + 2'd1;
					if (b_q == 2'(NUM_BANDS - 1)) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						prev_q <= knots;
						rpeak_q <= '0;
						apeak_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/ikd_checker.sv -----
`default_nettype none
module ikd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic full,
	input wire logic pop,
	input wire logic empty,
	input wire logic [3:0] knot_count,
	input wire logic [16:0] peak_rate,
	input wire logic [16:0] peak_accel_dev
);
	// a transaction on the input side occupies the front end
	a_busy_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full) else $error("front end free right after a transaction");

	a_knot_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (knot_count >= 4'd1 && knot_count <= 4'd8))
		else $error("knot count out of range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(knot_count) && $stable(peak_rate)
		&& $stable(peak_accel_dev)) else $error("waiting result changed");
endmodule

bind imu_excitation_knot_density_core ikd_checker u_ikd_checker (.*);
`default_nettype wire

// ----- test/tb_imu_excitation_knot_density_core.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_imu_excitation_knot_density_core;
	import ikd_pkg::*;

	typedef struct {
		logic [3:0] knots;
		logic [16:0] rate;
		logic [16:0] adev;
	} segment_result_t;

	class knot_scoreboard;
		logic [47:0] gyro_bias;
		logic [47:0] accel_bias;
		logic [15:0] gravity;
		logic [7:0] hys;
		logic [63:0] rate_thr;
		logic [63:0] accel_thr;
		logic [3:0] max_knots;
		logic [16:0] rate_peak;
		logic [16:0] adev_peak;
		logic [3:0] prev_knots;
		segment_result_t pending[$];
		int errors;

		function void init();
			gyro_bias = '0;
			accel_bias = '0;
			gravity = '0;
			hys = '0;
			rate_thr = '1;
			accel_thr = '1;
			max_knots = 4'd5;
			rate_peak = '0;
			adev_peak = '0;
			prev_knots = 4'd1;
			errors = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [63:0] d);
			case (idx)
				REG_GYRO_BIAS: gyro_bias = d[47:0];
				REG_ACCEL_BIAS: accel_bias = d[47:0];
				REG_GRAVITY: gravity = d[15:0];
				REG_HYSTERESIS: hys = d[7:0];
				REG_RATE_THR: rate_thr = d;
				REG_ACCEL_THR: accel_thr = d;
				REG_MAX_KNOTS: max_knots = d[3:0];
				default: ;
			endcase
		endfunction

		function logic [16:0] norm(logic [47:0] s, logic [47:0] b);
			longint unsigned sum;
			longint d;
			longint unsigned r;
			sum = 0;
			for (int k = 0; k < 3; k++) begin
				d = longint'($signed(s[16*k +: 16])) - longint'($signed(b[16*k +: 16]));
				sum += d * d;
			end
			r = 0;
			while ((r + 1) * (r + 1) <= sum) r++;
			return (r > 131071) ? 17'h1FFFF : r[16:0];
		endfunction

		function int bands(logic [16:0] v, logic [63:0] edges, int h, int held);
			longint unsigned e;
			int n;
			n = 0;
			for (int i = 0; i < NUM_BANDS; i++) begin
				e = edges[16*i +: 16];
				if (i < held ? (longint'(v) * 256 >= e * (256 - h)) : (v >= e)) n++;
				else break;
			end
			return n;
		endfunction

		function void note_sample(logic [47:0] g, logic [47:0] a, logic last);
			logic [16:0] w, an, dv;
			int h, held, nb, cap, k;
			segment_result_t r;
			w = norm(g, gyro_bias);
			an = norm(a, accel_bias);
			dv = (an >= gravity) ? an - gravity : gravity - an;
			if (w > rate_peak) rate_peak = w;
			if (dv > adev_peak) adev_peak = dv;
			if (!last) return;
			h = (hys > HYS_MAX) ? HYS_MAX : hys;
			held = (prev_knots > 0) ? prev_knots - 1 : 0;
			nb = bands(rate_peak, rate_thr, h, held);
			k = bands(adev_peak, accel_thr, h, held);
			if (k > nb) nb = k;
			cap = (max_knots < 1) ? 1 : max_knots;
			k = (nb + 1 > cap) ? cap : nb + 1;
			r.knots = k[3:0];
			r.rate = rate_peak;
			r.adev = adev_peak;
			pending.insert(pending.size(), r);
			prev_knots = k[3:0];
			rate_peak = '0;
			adev_peak = '0;
		endfunction

		function void check_result(logic [3:0] kc, logic [16:0] pr, logic [16:0] pa);
			segment_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
				return;
			end
			e = pending[0];
			pending.delete(0);
			if (kc !== e.knots) begin
				$error("knot_count exp %0d got %0d", e.knots, kc);
				errors++;
			end
			if (pr !== e.rate) begin
				$error("peak_rate exp %0d got %0d", e.rate, pr);
				errors++;
			end
			if (pa !== e.adev) begin
				$error("peak_accel_dev exp %0d got %0d", e.adev, pa);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, push, full, segment_end, empty, pop, wr_en;
	logic [15:0] gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z;
	logic [3:0] knot_count;
	logic [16:0] peak_rate, peak_accel_dev;
	logic [IDX_W-1:0] wr_index;
	logic [63:0] wr_data;
	knot_scoreboard sb;
	bit idle_on;

	imu_excitation_knot_density_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.gyro_x(gyro_x), .gyro_y(gyro_y), .gyro_z(gyro_z),
		.acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z), .segment_end(segment_end),
		.empty(empty), .pop(pop), .knot_count(knot_count), .peak_rate(peak_rate),
		.peak_accel_dev(peak_accel_dev), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic set_reg(logic [IDX_W-1:0] idx, logic [63:0] d);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(negedge clk);
		wr_en <= 1'b0;
		sb.write_reg(idx, d);
	endtask

	task automatic send_sample(logic [47:0] g, logic [47:0] a, logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		push <= 1'b1;
		{gyro_z, gyro_y, gyro_x} <= g;
		{acc_z, acc_y, acc_x} <= a;
		segment_end <= last;
		do @(posedge clk); while (full);
		sb.note_sample(g, a, last);
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		push <= 1'b0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [47:0] rand_vec();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [15:0] near(int c, int spread);
		return 16'(c + $urandom_range(0, 2 * spread) - spread);
	endfunction

	function automatic logic [63:0] rising_edges(int top);
		logic [63:0] v;
		int e;
		e = 0;
		for (int i = 0; i < 4; i++) begin
			e += $urandom_range(1, top / 4);
			v[16*i +: 16] = e[15:0];
		end
		return v;
	endfunction

	task automatic random_config(bit extreme);
		set_reg(REG_GYRO_BIAS, extreme ? 64'h8000_7FFF_FFFF : {near(0, 300), near(0, 300),
			near(0, 300)});
		set_reg(REG_ACCEL_BIAS, extreme ? 64'h7FFF_8000_0001 : {near(0, 300), near(0, 300),
			near(0, 300)});
		set_reg(REG_GRAVITY, extreme ? 64'hFFFF : $urandom_range(0, 20000));
		set_reg(REG_HYSTERESIS, extreme ? 64'hFF : $urandom_range(0, 253));
		set_reg(REG_RATE_THR, extreme ? {$urandom(), $urandom()} : rising_edges(40000));
		set_reg(REG_ACCEL_THR, extreme ? 64'h0 : rising_edges(30000));
		set_reg(REG_MAX_KNOTS, extreme ? $urandom_range(0, 15) : $urandom_range(1, 8));
		set_reg(3'd7, {$urandom(), $urandom()});
	endtask

	initial begin : consumer
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			if (arst_n && pop && !empty) sb.check_result(knot_count, peak_rate, peak_accel_dev);
		end
	end

	initial begin : stimulus
		int n, len;
		logic [47:0] g;
		sb = new();
		sb.init();
		push = 1'b0;
		segment_end = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		{gyro_x, gyro_y, gyro_z, acc_x, acc_y, acc_z} = '0;
		idle_on = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults, then directed extremes
		send_sample('0, '0, 1'b1);
		send_sample({3{16'h8000}}, {3{16'h8000}}, 1'b1);
		send_sample({3{16'h7FFF}}, {3{16'h8000}}, 1'b0);
		send_sample({3{16'hFFFF}}, {3{16'h0001}}, 1'b1);
		drain();
		random_config(1'b1);
		send_sample({3{16'h7FFF}}, {3{16'h8000}}, 1'b1);
		send_sample({3{16'h8000}}, {3{16'h7FFF}}, 1'b1);
		drain();
		set_reg(REG_RATE_THR, 64'h0010_0010_0080_0040);
		set_reg(REG_ACCEL_THR, 64'h4000_3000_2000_1000);
		set_reg(REG_GYRO_BIAS, 64'h0);
		set_reg(REG_ACCEL_BIAS, 64'h0);
		set_reg(REG_GRAVITY, 64'd4096);
		set_reg(REG_HYSTERESIS, 64'd253);
		set_reg(REG_MAX_KNOTS, 64'd8);
		send_sample({32'h0, 16'd100}, {32'h0, 16'd4096}, 1'b1);
		send_sample({32'h0, 16'd30}, {32'h0, 16'd4096}, 1'b1);
		send_sample({32'h0, 16'd0}, {32'h0, 16'd24000}, 1'b1);
		send_sample({32'h0, 16'd0}, {32'h0, 16'd100}, 1'b1);
		drain();

		idle_on = 1'b1;
		n = 0;
		while (n < 1400) begin
			if ($urandom_range(0, 4) == 0) begin
				drain();
				random_config($urandom_range(0, 5) == 0);
			end
			if (n > 1200) idle_on = 1'b0;
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				g = ($urandom_range(0, 9) == 0) ? rand_vec() :
					{near(0, 9000), near(0, 9000), near(0, 9000)};
				send_sample(g, ($urandom_range(0, 9) == 0) ? rand_vec() :
					{near(0, 6000), near(0, 6000), near(0, 9000) + 16'(sb.gravity)},
					i == len - 1);
				n++;
			end
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#8ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
design/ikd_pkg.sv
design/ikd_fifo.sv
design/ikd_front.sv
design/ikd_back.sv
design/imu_excitation_knot_density_core.sv
design/ikd_checker.sv
test/tb_imu_excitation_knot_density_core.sv
